/* rtl/rc5_ir_manchester_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// rc5 decoder assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RC5_IR_MANCHESTER_DECODER_UNIT_MACROS_SVH
`define RC5_IR_MANCHESTER_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked on clk, off during reset
`define RC5_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RC5_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RC5_ASSERT_IMPL(label, ante, cons)
`define RC5_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/rc5ir_pkg.sv */
// ----------------------------------------------------------------------------
// rc5ir_pkg
// shared types and constants of the rc5 infrared decoder
// ----------------------------------------------------------------------------
package rc5ir_pkg;

    localparam int FRAME_BITS = 14;
    localparam int CNT_W      = 4;
    localparam int TIME_W     = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_SHORT_HALF_BIT   = 2'd0;
    localparam logic [1:0] CFG_LONG_BIT         = 2'd1;
    localparam logic [1:0] CFG_TIMING_TOLERANCE = 2'd2;
    localparam logic [1:0] CFG_TICK_PRESCALE    = 2'd3;

    // classified edge event passed from front to back
    typedef struct packed {
        logic timeout;
        logic level;
        logic short_hit;
        logic long_hit;
    } class_t;

    localparam int CLASS_W = $bits(class_t);

endpackage

/* rtl/rc5ir_fifo.sv */
// ----------------------------------------------------------------------------
// rc5ir_fifo
// small flop-based first-in first-out queue
// ----------------------------------------------------------------------------
module rc5ir_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/rc5ir_front.sv */
// ----------------------------------------------------------------------------
// rc5ir_front
// configuration registers, tick scaling and timing window classification
// ----------------------------------------------------------------------------
module rc5ir_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  mode,
    input  logic                  line_level,
    input  logic [15:0]           elapsed_ticks,
    input  logic                  cls_full,
    output logic                  cls_push,
    output rc5ir_pkg::class_t     cls
);

    import rc5ir_pkg::*;

    logic [15:0]       short_half_bit_reg;
    logic [15:0]       long_bit_reg;
    logic [15:0]       timing_tolerance_reg;
    logic [7:0]        tick_prescale_reg;

    logic              a_valid_reg, a_valid_next;
    logic              a_mode_reg;
    logic              a_level_reg;
    logic [TIME_W-1:0] a_time_reg;
    logic              accept;

    logic [TIME_W-1:0] diff_short;
    logic [TIME_W-1:0] diff_long;
    logic [TIME_W-1:0] nom_short;
    logic [TIME_W-1:0] nom_long;
    logic [TIME_W-1:0] tol;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_half_bit_reg   <= 16'd889;
            long_bit_reg         <= 16'd1778;
            timing_tolerance_reg <= 16'd300;
            tick_prescale_reg    <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHORT_HALF_BIT:   short_half_bit_reg   <= cfg_data;
                CFG_LONG_BIT:         long_bit_reg         <= cfg_data;
                CFG_TIMING_TOLERANCE: timing_tolerance_reg <= cfg_data;
                CFG_TICK_PRESCALE:    tick_prescale_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage holds the scaled time until the class queue has room
    assign full     = a_valid_reg && cls_full;
    assign accept   = push && !full;
    assign cls_push = a_valid_reg && !cls_full;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (cls_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mode_reg  <= mode;
            a_level_reg <= line_level;
            a_time_reg  <= TIME_W'(elapsed_ticks) * TIME_W'(tick_prescale_reg);
        end
    end

    assign nom_short = TIME_W'(short_half_bit_reg);
    assign nom_long  = TIME_W'(long_bit_reg);
    assign tol       = TIME_W'(timing_tolerance_reg);

    assign diff_short = (a_time_reg >= nom_short) ? a_time_reg - nom_short
                                                  : nom_short - a_time_reg;
    assign diff_long  = (a_time_reg >= nom_long) ? a_time_reg - nom_long
                                                 : nom_long - a_time_reg;

    always_comb
    begin
        cls.timeout   = a_mode_reg;
        cls.level     = a_level_reg;
        cls.short_hit = (diff_short <= tol);
        cls.long_hit  = (diff_long <= tol);
    end

endmodule

/* rtl/rc5ir_back.sv */
// ----------------------------------------------------------------------------
// rc5ir_back
// manchester state graph, bit shifter and frame completion
// ----------------------------------------------------------------------------
module rc5ir_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rc5ir_pkg::class_t              cls,
    input  logic                           cls_empty,
    output logic                           cls_pop,
    input  logic                           frame_full,
    output logic                           frame_push,
    output logic [rc5ir_pkg::FRAME_BITS-1:0] frame
);

    import rc5ir_pkg::*;

    typedef enum logic [4:0] {
        ST_RESET  = 5'b00001,
        ST_START1 = 5'b00010,
        ST_MID1   = 5'b00100,
        ST_START0 = 5'b01000,
        ST_MID0   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;

    state_t                st_step;
    logic                  do_shift;
    logic                  shift_val;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      cnt_step;
    logic [FRAME_BITS-1:0] frame_step;
    logic                  space;
    logic                  pulse;

    assign cls_pop = !cls_empty && !frame_full;
    assign space   = cls.level;
    assign pulse   = !cls.level;
    assign pos     = CNT_W'(FRAME_BITS - 1) - bit_count_reg;

    always_comb
    begin
        st_step   = state_reg;
        do_shift  = 1'b0;
        shift_val = 1'b0;
        case (state_reg)
            ST_START1:
            begin
                if (space && cls.short_hit)
                begin
                    st_step   = ST_MID1;
                    do_shift  = 1'b1;
                    shift_val = 1'b1;
                end
            end
            ST_MID1:
            begin
                if (pulse && cls.short_hit)
                begin
                    st_step = ST_START1;
                end
                else if (pulse && cls.long_hit)
                begin
                    st_step  = ST_MID0;
                    do_shift = 1'b1;
                end
            end
            ST_MID0:
            begin
                if (space && cls.long_hit)
                begin
                    st_step   = ST_MID1;
                    do_shift  = 1'b1;
                    shift_val = 1'b1;
                end
                else if (space && cls.short_hit)
                begin
                    st_step = ST_START0;
                end
            end
            ST_START0:
            begin
                if (pulse && cls.short_hit)
                begin
                    st_step  = ST_MID0;
                    do_shift = 1'b1;
                end
            end
            default:
            begin
                // idle: any edge is the first start bit
                st_step   = ST_MID1;
                do_shift  = 1'b1;
                shift_val = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt_step   = bit_count_reg;
        frame_step = frame_reg;
        if (do_shift)
        begin
            if (bit_count_reg < CNT_W'(FRAME_BITS))
            begin
                frame_step[pos] = shift_val;
            end
            cnt_step = bit_count_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_count_next = bit_count_reg;
        frame_next     = frame_reg;
        frame_push     = 1'b0;
        if (cls_pop)
        begin
            if (cls.timeout)
            begin
                state_next     = ST_RESET;
                bit_count_next = '0;
                frame_next     = '0;
            end
            else if (cnt_step == CNT_W'(2) &&
                     frame_step[FRAME_BITS-1:FRAME_BITS-2] != 2'b11)
            begin
                // start bits not both one
                state_next     = ST_RESET;
                bit_count_next = '0;
                frame_next     = '0;
            end
            else if (cnt_step == CNT_W'(FRAME_BITS))
            begin
                frame_push     = 1'b1;
                state_next     = ST_RESET;
                bit_count_next = '0;
                frame_next     = '0;
            end
            else
            begin
                state_next     = st_step;
                bit_count_next = cnt_step;
                frame_next     = frame_step;
            end
        end
    end

    assign frame = frame_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RESET;
            bit_count_reg <= '0;
            frame_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_count_reg <= bit_count_next;
            frame_reg     <= frame_next;
        end
    end

endmodule

/* rtl/rc5_ir_manchester_decoder_unit.sv */
// ----------------------------------------------------------------------------
// rc5_ir_manchester_decoder_unit
// rc5 infrared manchester frame decoder driven by edge and timeout events
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload
//  -------   -----------------   ------------------------------------------
//  input     push / full         mode, line_level, elapsed_ticks
//  result    pop / empty         start_bits, toggle, address, command
//  config    cfg_we              cfg_index, cfg_data
//
//  one event accepted per cycle while full is low; the event that completes
//  a frame goes through scale stage, class queue and back to the result queue
//  the tick multiply sits in the input stage, the window compare after it
//  reset restores the register defaults and idles the decoder, no sweep
//  full rises only when the class queue is full and the input stage holds
//  the state graph stops while the result queue is full
//
module rc5_ir_manchester_decoder_unit #(
    parameter int CLASS_DEPTH = 4,
    parameter int OUT_DEPTH   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic        line_level,
    input  logic [15:0] elapsed_ticks,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  start_bits,
    output logic        toggle,
    output logic [4:0]  address,
    output logic [5:0]  command
);

    import rc5ir_pkg::*;

    `include "rc5_ir_manchester_decoder_unit_macros.svh"

    class_t                cls_in;
    class_t                cls_out;
    logic [CLASS_W-1:0]    cls_rdata;
    logic                  cls_push;
    logic                  cls_pop;
    logic                  cls_full;
    logic                  cls_empty;
    logic [FRAME_BITS-1:0] frame_wdata;
    logic [FRAME_BITS-1:0] frame_rdata;
    logic                  frame_push;
    logic                  out_full;

    rc5ir_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .line_level    (line_level),
        .elapsed_ticks (elapsed_ticks),
        .cls_full      (cls_full),
        .cls_push      (cls_push),
        .cls           (cls_in)
    );

    rc5ir_fifo #(
        .WIDTH (CLASS_W),
        .DEPTH (CLASS_DEPTH)
    ) u_cls_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cls_push),
        .wdata (cls_in),
        .pop   (cls_pop),
        .rdata (cls_rdata),
        .full  (cls_full),
        .empty (cls_empty)
    );

    assign cls_out = class_t'(cls_rdata);

    rc5ir_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cls        (cls_out),
        .cls_empty  (cls_empty),
        .cls_pop    (cls_pop),
        .frame_full (out_full),
        .frame_push (frame_push),
        .frame      (frame_wdata)
    );

    rc5ir_fifo #(
        .WIDTH (FRAME_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (frame_push),
        .wdata (frame_wdata),
        .pop   (pop),
        .rdata (frame_rdata),
        .full  (out_full),
        .empty (empty)
    );

    assign start_bits = frame_rdata[13:12];
    assign toggle     = frame_rdata[11];
    assign address    = frame_rdata[10:6];
    assign command    = frame_rdata[5:0];

    // front never writes a full class queue
    `RC5_ASSERT_IMPL(a_cls_no_overflow, cls_push, !cls_full)
    // back only steps with an event waiting and room for a result
    `RC5_ASSERT_IMPL(a_back_step_ok, cls_pop, !cls_empty && !out_full)
    // a delivered frame always carries both start bits set
    `RC5_ASSERT_IMPL(a_start_bits_set, !empty, start_bits == 2'b11)
    // a completed frame is in the result queue in the next cycle
    `RC5_ASSERT_NEXT(a_frame_lands, frame_push, !empty)

endmodule
